// ===== rtl/core/mlh_pkg.sv =====
// Shared constants, codes and types for the monotone line hull query block.
package mlh_pkg;

   // Hull store geometry
   localparam int MAX_LINES = 1024;
   localparam int ADDR_W    = $clog2(MAX_LINES);
   localparam int COUNT_W   = ADDR_W + 1;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int VAL_W      = 32;
   localparam int IDENT_W    = 16;
   localparam int STATUS_W   = 2;
   localparam int OPND_W     = VAL_W + 1;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int REQ_DATA_W = 3 * VAL_W + IDENT_W;
   localparam int RSP_DATA_W = IDENT_W;

   // Request kinds
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNUSED = 2'd3;

   // Classified request as held in the queue
   typedef struct packed {
      logic                     op;
      logic signed [VAL_W-1:0]  operand;    // slope for an add, x for a query
      logic signed [VAL_W-1:0]  intercept;
      logic [IDENT_W-1:0]       ident;
   } item_type;

   // One stored hull line
   typedef struct packed {
      logic signed [VAL_W-1:0]  slope;
      logic signed [VAL_W-1:0]  intercept;
      logic [IDENT_W-1:0]       ident;
   } line_type;

endpackage

// ===== rtl/core/mlh_front.sv =====
// Front end: takes request beats, classifies them and hands them to the queue.
module mlh_front
   import mlh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  push_valid,
   input  logic                  push_ready,
   output item_type              push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;

   // Decode the beat: the operand carries slope or x depending on the kind
   always_comb begin
      item_in.op        = req_tuser;
      item_in.operand   = (req_tuser == OP_QUERY) ? req_tdata[REQ_DATA_W-1 -: VAL_W]
                                                  : req_tdata[VAL_W-1:0];
      item_in.intercept = req_tdata[2*VAL_W-1:VAL_W];
      item_in.ident     = req_tdata[2*VAL_W+IDENT_W-1:2*VAL_W];
   end

   assign req_tready = !valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;

   // Holding stage ahead of the queue
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

// ===== rtl/core/mlh_queue.sv =====
// Short queue of classified requests between the front and the back end.
module mlh_queue
   import mlh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0]   count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = (count_ff != QCOUNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/core/mlh_engine.sv =====
// Back end: hull store, pop test, forward scan for queries and result register.
module mlh_engine
   import mlh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  item_type              item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ADD_CHECK = 4'd1;
   localparam logic [3:0] S_ADD_OPS   = 4'd2;
   localparam logic [3:0] S_ADD_MUL   = 4'd3;
   localparam logic [3:0] S_ADD_CMP   = 4'd4;
   localparam logic [3:0] S_ADD_PUSH  = 4'd5;
   localparam logic [3:0] S_Q_START   = 4'd6;
   localparam logic [3:0] S_Q_READ    = 4'd7;
   localparam logic [3:0] S_Q_OPS     = 4'd8;
   localparam logic [3:0] S_Q_MUL     = 4'd9;
   localparam logic [3:0] S_Q_CMP     = 4'd10;
   localparam logic [3:0] S_RESP      = 4'd11;

   logic [3:0]                state_ff, state_in;
   item_type                  cur_ff, cur_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]         ptr_ff, ptr_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [IDENT_W-1:0]        res_index_ff, res_index_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [IDENT_W-1:0]        rsp_index_ff;

   // Shared multiplier pair operands and products
   logic signed [OPND_W-1:0]  opa0_ff, opa0_in, opb0_ff, opb0_in;
   logic signed [OPND_W-1:0]  opa1_ff, opa1_in, opb1_ff, opb1_in;
   logic signed [PROD_W-1:0]  prod0_ff, prod1_ff;

   // Hull store, two registered read ports and one write port
   line_type                  hull_mem [MAX_LINES];
   line_type                  rd0_ff, rd1_ff;
   logic                      rd_en, wr_en;
   logic [ADDR_W-1:0]         rd_addr0, rd_addr1;
   line_type                  wr_line;

   logic [COUNT_W-1:0]        count_m1, count_m2, ptr_next_wide;
   logic                      load_rsp;

   assign count_m1      = count_ff - COUNT_W'(1);
   assign count_m2      = count_ff - COUNT_W'(2);
   assign ptr_next_wide = {1'b0, ptr_ff} + COUNT_W'(1);
   assign load_rsp      = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   assign wr_line.slope     = cur_ff.operand;
   assign wr_line.intercept = cur_ff.intercept;
   assign wr_line.ident     = cur_ff.ident;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      opa0_in       = opa0_ff;
      opb0_in       = opb0_ff;
      opa1_in       = opa1_ff;
      opb1_in       = opb1_ff;
      item_ready    = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      rd_addr0      = ptr_ff;
      rd_addr1      = ptr_ff + ADDR_W'(1);
      case (state_ff)
         S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               cur_in   = item;
               state_in = (item.op == OP_QUERY) ? S_Q_START : S_ADD_CHECK;
            end
         end
         // Read the last two stored lines if there are two
         S_ADD_CHECK: begin
            if (count_ff >= COUNT_W'(2)) begin
               rd_en    = 1'b1;
               rd_addr0 = count_m2[ADDR_W-1:0];
               rd_addr1 = count_m1[ADDR_W-1:0];
               state_in = S_ADD_OPS;
            end else begin
               state_in = S_ADD_PUSH;
            end
         end
         // (n - na) * (ma - mb)  against  (ma - m) * (nb - na)
         S_ADD_OPS: begin
            opa0_in  = {cur_ff.intercept[VAL_W-1], cur_ff.intercept}
                     - {rd0_ff.intercept[VAL_W-1], rd0_ff.intercept};
            opb0_in  = {rd0_ff.slope[VAL_W-1], rd0_ff.slope}
                     - {rd1_ff.slope[VAL_W-1], rd1_ff.slope};
            opa1_in  = {rd0_ff.slope[VAL_W-1], rd0_ff.slope}
                     - {cur_ff.operand[VAL_W-1], cur_ff.operand};
            opb1_in  = {rd1_ff.intercept[VAL_W-1], rd1_ff.intercept}
                     - {rd0_ff.intercept[VAL_W-1], rd0_ff.intercept};
            state_in = S_ADD_MUL;
         end
         S_ADD_MUL: begin
            state_in = S_ADD_CMP;
         end
         S_ADD_CMP: begin
            if (prod0_ff <= prod1_ff) begin
               count_in = count_m1;
               state_in = S_ADD_CHECK;
            end else begin
               state_in = S_ADD_PUSH;
            end
         end
         S_ADD_PUSH: begin
            res_index_in = '0;
            if (count_ff < COUNT_W'(MAX_LINES)) begin
               wr_en         = 1'b1;
               count_in      = count_ff + COUNT_W'(1);
               res_status_in = ST_OK;
            end else begin
               res_status_in = ST_FULL;
            end
            state_in = S_RESP;
         end
         // Empty hull check and pointer clamp
         S_Q_START: begin
            if (count_ff == '0) begin
               res_status_in = ST_EMPTY;
               res_index_in  = '0;
               state_in      = S_RESP;
            end else begin
               if ({1'b0, ptr_ff} >= count_ff) begin
                  ptr_in = count_m1[ADDR_W-1:0];
               end
               state_in = S_Q_READ;
            end
         end
         S_Q_READ: begin
            rd_en    = 1'b1;
            state_in = S_Q_OPS;
         end
         // Next line is better when (m1 - m0) * x < n0 - n1
         S_Q_OPS: begin
            if (ptr_next_wide < count_ff) begin
               opa0_in  = {rd1_ff.slope[VAL_W-1], rd1_ff.slope}
                        - {rd0_ff.slope[VAL_W-1], rd0_ff.slope};
               opb0_in  = {cur_ff.operand[VAL_W-1], cur_ff.operand};
               opa1_in  = {rd0_ff.intercept[VAL_W-1], rd0_ff.intercept}
                        - {rd1_ff.intercept[VAL_W-1], rd1_ff.intercept};
               opb1_in  = OPND_W'(1);
               state_in = S_Q_MUL;
            end else begin
               res_status_in = ST_OK;
               res_index_in  = rd0_ff.ident;
               state_in      = S_RESP;
            end
         end
         S_Q_MUL: begin
            state_in = S_Q_CMP;
         end
         S_Q_CMP: begin
            if (prod0_ff < prod1_ff) begin
               ptr_in   = ptr_ff + ADDR_W'(1);
               state_in = S_Q_READ;
            end else begin
               res_status_in = ST_OK;
               res_index_in  = rd0_ff.ident;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: holds while the receiver stalls
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      opa0_ff       <= opa0_in;
      opb0_ff       <= opb0_in;
      opa1_ff       <= opa1_in;
      opb1_ff       <= opb1_in;
      prod0_ff      <= opa0_ff * opb0_ff;
      prod1_ff      <= opa1_ff * opb1_ff;
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_index_ff  <= res_index_ff;
      end
   end

   // Hull store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hull_mem[count_ff[ADDR_W-1:0]] <= wr_line;
      end
      if (rd_en) begin
         rd0_ff <= hull_mem[rd_addr0];
         rd1_ff <= hull_mem[rd_addr1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_index_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/core/monotone_line_hull_min_query.sv =====
// Top level of the monotone line hull minimum query block.
//
// Usage: each request beat on the req_ channel either adds a line
// y = slope*x + intercept (tuser = add) or asks for the line that is lowest
// at x_value (tuser = query). Lines are expected in strictly descending
// slope, queries in non-decreasing x. Every request gives one beat on the
// rsp_ channel: a status (ok, add dropped because the store is full, query
// on an empty hull) and, for a good query, the caller's line identifier.
// Flow: a request passes the front stage and the queue, then the back end
// works on it alone. An add's time grows with each popped line, a query's
// with each pointer step; an add with fewer than two lines stored, or a
// query on an empty hull or at the hull's end, needs no multiplier pass. Each
// pop test or pointer step is one pass of two reads of the dual-read hull
// memory followed by the shared 33x33 multiplier pair and a wide compare.
// Up to three requests queue in front of the engine.
// Reset empties the hull and the scan pointer; no clearing pass is needed.
// A stalled receiver holds the result register; the engine then waits for
// it and the queue fills before req_tready drops.
module monotone_line_hull_min_query
   import mlh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // slope, intercept, line_index, x_value
   input  logic                  req_tuser,   // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // best_index
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     eng_valid, eng_ready;
   item_type eng_item;

   mlh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   mlh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (eng_valid),
      .out_ready (eng_ready),
      .out_item  (eng_item)
   );

   mlh_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (eng_valid),
      .item_ready (eng_ready),
      .item       (eng_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/mlh_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
module mlh_checker
   import mlh_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Nothing comes out in the cycle after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // Status never takes the unused code
   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != ST_UNUSED)
      else $error("unused status code");

   // Failed requests carry a zero identifier
   a_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_EMPTY) |-> rsp_tdata == '0)
      else $error("non-zero identifier on a failed request");

endmodule

bind monotone_line_hull_min_query mlh_checker u_mlh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
